>>> hdl/sgacc_pkg.sv
package sgacc_pkg;

    localparam int CW     = 32;               // field width
    localparam int FB     = 16;               // fraction bits
    localparam int AW     = CW + 1;           // magnitude of a coordinate difference
    localparam int SW     = 2 * AW + 1;       // r^2 + eps^2
    localparam int NW     = AW + CW;          // |d| * mass
    localparam int MA_W   = 2 * SW;           // multiplier operand a
    localparam int MB_W   = SW;               // multiplier operand b
    localparam int MP_W   = MA_W + MB_W;      // multiplier product
    localparam int CH     = 8;                // operand b bits per multiplier stage
    localparam int MUL_ST = (MB_W + CH - 1) / CH;
    localparam int MW     = 2 * NW + 4 * FB;  // squared numerator
    localparam int QW     = MP_W + CW;        // k * s^3
    localparam int RW     = MP_W + 2 * CW + 1; // trial k^2 * s^3
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [SW-1:0]        s;
        logic [2:0][NW-1:0]   n;
        logic [2:0]           neg;
    } job_t;

    typedef struct packed {
        logic [2:0][CW-1:0]   acc;
        logic                 clipped;
    } res_t;

endpackage

>>> hdl/softened_gravity_acceleration.sv
// throughput: one item per cycle; the front stalls only when its queue is full, the back
//   only when its two-entry result buffer is full
// front: 3 stages (difference, squares and products, sum); back: 2 x 9 multiplier stages
//   for s^2 and s^3, then 32 search stages, one result bit each
// reset: rst_n asynchronous, active low; empties both queues, softening clears to zero
module softened_gravity_acceleration
    import sgacc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // item side
    input  logic          push,
    output logic          full,
    input  logic [CW-1:0] body_x,
    input  logic [CW-1:0] body_y,
    input  logic [CW-1:0] body_z,
    input  logic [CW-1:0] other_x,
    input  logic [CW-1:0] other_y,
    input  logic [CW-1:0] other_z,
    input  logic [CW-1:0] src_mass,
    // softening register
    input  logic          softening_we,
    input  logic [CW-1:0] softening,
    // result side
    output logic          empty,
    input  logic          pop,
    output logic [CW-1:0] acc_x,
    output logic [CW-1:0] acc_y,
    output logic [CW-1:0] acc_z,
    output logic          clipped
);

    logic [CW-1:0] eps_reg;
    logic          q_push, q_full, q_pop, q_empty;
    job_t          q_in, q_out;
    res_t          res;

    // softening length, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= '0;
        else if (softening_we)
            eps_reg <= softening;
    end

    // an item is taken whenever the job queue has room
    assign full = q_full;

    // front: differences, squared distance, |d| * mass
    sgacc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .bpos   ({body_z, body_y, body_x}),
        .opos   ({other_z, other_y, other_x}),
        .mass   (src_mass),
        .eps    (eps_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_in)
    );

    // job queue decouples front from back
    sgacc_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    // back: s^3, n^2 and the quotient search, then saturation
    sgacc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (q_out),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign acc_x   = res.acc[0];
    assign acc_y   = res.acc[1];
    assign acc_z   = res.acc[2];
    assign clipped = res.clipped;

endmodule

>>> hdl/sgacc_front.sv
module sgacc_front
    import sgacc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [2:0][CW-1:0] bpos,
    input  logic [2:0][CW-1:0] opos,
    input  logic [CW-1:0]      mass,
    input  logic [CW-1:0]      eps,
    input  logic               q_full,
    output logic               q_push,
    output job_t               q_item
);

    logic               en;
    logic               v1_reg, v2_reg, v3_reg;
    logic [2:0][AW-1:0] mag1_reg;
    logic [2:0]         neg1_reg, neg2_reg;
    logic [CW-1:0]      mass1_reg, eps1_reg;
    logic [2:0][2*AW-1:0] sq2_reg;
    logic [2:0][NW-1:0] n2_reg;
    logic [2*CW-1:0]    eps2_reg;
    job_t               item3_reg;
    logic [2:0][AW-1:0] d;
    logic [2:0][AW-1:0] mag;

    assign en = !q_full;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i]   = {opos[i][CW-1], opos[i]} - {bpos[i][CW-1], bpos[i]};
            mag[i] = d[i][AW-1] ? (~d[i] + AW'(1)) : d[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag[i];
                neg1_reg[i] <= d[i][AW-1];
                sq2_reg[i]  <= (2*AW)'(mag1_reg[i]) * (2*AW)'(mag1_reg[i]);
                n2_reg[i]   <= NW'(mag1_reg[i]) * NW'(mass1_reg);
            end
            mass1_reg      <= mass;
            eps1_reg       <= eps;
            eps2_reg       <= (2*CW)'(eps1_reg) * (2*CW)'(eps1_reg);
            neg2_reg       <= neg1_reg;
            item3_reg.s    <= SW'(sq2_reg[0]) + SW'(sq2_reg[1]) + SW'(sq2_reg[2])
                              + SW'(eps2_reg);
            item3_reg.n    <= n2_reg;
            item3_reg.neg  <= neg2_reg;
        end
    end

    assign q_push = en && v3_reg;
    assign q_item = item3_reg;

endmodule

>>> hdl/sgacc_fifo.sv
module sgacc_fifo
    import sgacc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t din,
    output logic full,
    input  logic pop,
    output job_t dout,
    output logic empty
);

    job_t            mem [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]    cnt_reg;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == (QAW+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + (QAW+1)'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= din;
    end

endmodule

>>> hdl/sgacc_mul.sv
module sgacc_mul
    import sgacc_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [MA_W-1:0] a,
    input  logic [MB_W-1:0] b,
    output logic [MP_W-1:0] p
);

    // one chunk of b per stage, partial products accumulate down the pipe
    logic [MUL_ST*CH-1:0] b_ext;
    logic [MA_W-1:0]      a_reg   [MUL_ST];
    logic [MUL_ST*CH-1:0] b_reg   [MUL_ST];
    logic [MP_W-1:0]      acc_reg [MUL_ST];

    assign b_ext = (MUL_ST*CH)'(b);

    for (genvar i = 0; i < MUL_ST; i++)
    begin : g_st
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[0]   <= a;
                    b_reg[0]   <= b_ext;
                    acc_reg[0] <= MP_W'(a) * MP_W'(b_ext[CH-1:0]);
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[i]   <= a_reg[i-1];
                    b_reg[i]   <= b_reg[i-1];
                    acc_reg[i] <= acc_reg[i-1]
                                  + ((MP_W'(a_reg[i-1]) * MP_W'(b_reg[i-1][i*CH +: CH]))
                                     << (i*CH));
                end
            end
        end
    end

    assign p = acc_reg[MUL_ST-1] ^ (MP_W'(a_reg[MUL_ST-1]) & '0) ^ (MP_W'(b_reg[MUL_ST-1]) & '0);

endmodule

>>> hdl/sgacc_back.sv
module sgacc_back
    import sgacc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  job_t q_item,
    output logic q_pop,
    input  logic pop,
    output logic empty,
    output res_t res
);

    localparam int DL = 2 * MUL_ST;

    logic            en;
    logic [MP_W-1:0] s2_p, s3_p;
    logic [MP_W-1:0] n2_p [3];

    logic            vd_reg   [DL];
    logic            zd_reg   [DL];
    logic [2:0]      negd_reg [DL];
    logic [SW-1:0]   sd_reg   [MUL_ST];
    logic [2*NW-1:0] n2d_reg  [3][MUL_ST];

    logic            sv_reg   [CW+1];
    logic            sz_reg   [CW+1];
    logic [2:0]      sneg_reg [CW+1];
    logic [MP_W-1:0] s3_reg   [CW];
    logic [RW-1:0]   p_reg    [3][CW];
    logic [QW-1:0]   qq_reg   [3][CW];
    logic [MW-1:0]   m_reg    [3][CW];
    logic [CW-1:0]   k_reg    [3][CW+1];

    res_t            ob_reg [2];
    logic            o_wr_reg, o_rd_reg;
    logic [1:0]      o_cnt_reg;
    logic            o_full, o_push, o_pop;
    res_t            fin;

    assign o_full = (o_cnt_reg == 2'd2);
    assign en     = !o_full;
    assign q_pop  = en && !q_empty;

    sgacc_mul u_mul_s2 (.clk(clk), .en(en), .a(MA_W'(q_item.s)), .b(q_item.s), .p(s2_p));
    sgacc_mul u_mul_s3 (.clk(clk), .en(en), .a(s2_p[MA_W-1:0]), .b(sd_reg[MUL_ST-1]),
                        .p(s3_p));

    for (genvar l = 0; l < 3; l++)
    begin : g_nmul
        sgacc_mul u_mul_n (.clk(clk), .en(en), .a(MA_W'(q_item.n[l])),
                           .b(MB_W'(q_item.n[l])), .p(n2_p[l]));
    end

    // control: valid bits down the whole pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DL; i++)
                vd_reg[i] <= 1'b0;
            for (int i = 0; i <= CW; i++)
                sv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vd_reg[0] <= !q_empty;
            for (int i = 1; i < DL; i++)
                vd_reg[i] <= vd_reg[i-1];
            sv_reg[0] <= vd_reg[DL-1];
            for (int i = 1; i <= CW; i++)
                sv_reg[i] <= sv_reg[i-1];
        end
    end

    // side data that rides along with the multipliers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zd_reg[0]   <= (q_item.s == '0);
            negd_reg[0] <= q_item.neg;
            sd_reg[0]   <= q_item.s;
            for (int i = 1; i < DL; i++)
            begin
                zd_reg[i]   <= zd_reg[i-1];
                negd_reg[i] <= negd_reg[i-1];
            end
            for (int i = 1; i < MUL_ST; i++)
                sd_reg[i] <= sd_reg[i-1];
            for (int l = 0; l < 3; l++)
            begin
                n2d_reg[l][0] <= n2_p[l][2*NW-1:0];
                for (int i = 1; i < MUL_ST; i++)
                    n2d_reg[l][i] <= n2d_reg[l][i-1];
            end
            sz_reg[0]   <= zd_reg[DL-1];
            sneg_reg[0] <= negd_reg[DL-1];
            s3_reg[0]   <= s3_p;
            for (int i = 1; i <= CW; i++)
            begin
                sz_reg[i]   <= sz_reg[i-1];
                sneg_reg[i] <= sneg_reg[i-1];
            end
            for (int i = 1; i < CW; i++)
                s3_reg[i] <= s3_reg[i-1];
        end
    end

    // restoring search for the largest k with k^2 * s^3 <= n^2, one bit per stage
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[l][0]  <= '0;
                qq_reg[l][0] <= '0;
                k_reg[l][0]  <= '0;
                m_reg[l][0]  <= {n2d_reg[l][MUL_ST-1], (4*FB)'(0)};
            end
        end

        for (genvar j = 0; j < CW; j++)
        begin : g_bit
            localparam int B = CW - 1 - j;
            logic [RW-1:0] cand;
            logic          ok;

            assign cand = p_reg[l][j] + (RW'(qq_reg[l][j]) << (B + 1))
                          + (RW'(s3_reg[j]) << (2 * B));
            assign ok   = (cand <= RW'(m_reg[l][j]));

            always_ff @(posedge clk)
            begin
                if (en)
                    k_reg[l][j+1] <= k_reg[l][j] | (ok ? (CW'(1) << B) : '0);
            end

            if (j < CW - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        p_reg[l][j+1]  <= ok ? cand : p_reg[l][j];
                        qq_reg[l][j+1] <= ok ? (qq_reg[l][j] + (QW'(s3_reg[j]) << B))
                                             : qq_reg[l][j];
                        m_reg[l][j+1]  <= m_reg[l][j];
                    end
                end
            end
        end
    end

    // saturation and sign; a zero s gives a zero result with clipped set
    always_comb
    begin
        logic [CW-1:0] lim;
        logic [CW-1:0] sat;
        logic          clip;
        fin.clipped = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            lim  = sneg_reg[CW][l] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            clip = (k_reg[l][CW] > lim);
            sat  = clip ? lim : k_reg[l][CW];
            fin.acc[l]  = sneg_reg[CW][l] ? (~sat + CW'(1)) : sat;
            fin.clipped = fin.clipped | clip;
        end
        if (sz_reg[CW])
        begin
            fin.acc     = '0;
            fin.clipped = 1'b1;
        end
    end

    // two-entry output buffer
    assign o_push = en && sv_reg[CW];
    assign o_pop  = pop && (o_cnt_reg != 2'd0);
    assign empty  = (o_cnt_reg == 2'd0);
    assign res    = ob_reg[o_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_wr_reg  <= 1'b0;
            o_rd_reg  <= 1'b0;
            o_cnt_reg <= 2'd0;
        end
        else
        begin
            if (o_push)
                o_wr_reg <= !o_wr_reg;
            if (o_pop)
                o_rd_reg <= !o_rd_reg;
            if (o_push && !o_pop)
                o_cnt_reg <= o_cnt_reg + 2'd1;
            else if (o_pop && !o_push)
                o_cnt_reg <= o_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_push)
            ob_reg[o_wr_reg] <= fin;
    end

endmodule

>>> hdl/sgacc_checker.sv
module sgacc_checker
    import sgacc_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input logic [CW-1:0] acc_x,
    input logic [CW-1:0] acc_y,
    input logic [CW-1:0] acc_z,
    input logic          clipped
);

    // result queue empty and job queue not full while in reset
    a_reset: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queues not empty in reset");

    // the input backs up only behind waiting results
    a_full: assert property (@(posedge clk) disable iff (!rst_n) $rose(full) |-> !empty)
        else $error("full without waiting results");

    // a waiting result stays put until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(acc_x) && $stable(acc_y)
                              && $stable(acc_z) && $stable(clipped)))
        else $error("waiting result changed");

endmodule

bind softened_gravity_acceleration sgacc_checker u_chk (.*);
